[hdl/byte_ring_buffer_assert.svh]
// assertion macros used by the byte ring buffer rtl
// expects a clock i_clk and an active-low reset i_rst_n in the including module
`ifndef BYTE_RING_BUFFER_ASSERT_SVH
`define BYTE_RING_BUFFER_ASSERT_SVH

// condition in the same cycle implies the check in the same cycle
`define BRB_ASSERT_SAME(label, cond, check) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (check)) \
        else $error("byte ring buffer check failed");

// condition in one cycle implies the check in the next cycle
`define BRB_ASSERT_NEXT(label, cond, check) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (check)) \
        else $error("byte ring buffer check failed");

`endif

[hdl/brb_pkg.sv]
// types, codes and constants of the byte ring buffer
// used by brb_front, brb_back and byte_ring_buffer; depends on nothing
`timescale 1ns / 1ps

package brb_pkg;

    localparam int DEF_BUFFER_DEPTH = 64;
    localparam int CNT_W            = 7;
    localparam int CQ_DEPTH         = 2;
    localparam int OQ_DEPTH         = 4;

    typedef enum logic [1:0] {
        OP_WRITE       = 2'd0,
        OP_PEEK        = 2'd1,
        OP_ADVANCE     = 2'd2,
        OP_PEEK_CONTIG = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_NONE    = 3'd1,
        ST_WR_OK   = 3'd2,
        ST_WR_REJ  = 3'd3,
        ST_ADV     = 3'd4,
        ST_ADV_IGN = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CK_WRITE,
        CK_PEEK,
        CK_ADVANCE
    } t_cmd_kind;

    typedef enum logic {
        BK_IDLE,
        BK_PEEK
    } t_back_state;

    typedef struct packed {
        t_op              operation;
        logic [CNT_W-1:0] count;
        logic [7:0]       data_byte;
        logic             last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       data_byte_out;
        t_status          status;
        logic [CNT_W-1:0] returned_count;
        logic             last;
    } t_out_item;

    // classified command handed from the front to the back
    typedef struct packed {
        t_cmd_kind        kind;
        logic             contig;
        logic             count_zero;
        logic [CNT_W-1:0] count;
        logic [7:0]       data_byte;
        logic             last_byte;
    } t_cmd;

    // result slot travelling beside the store read
    typedef struct packed {
        logic             is_data;
        t_status          status;
        logic [CNT_W-1:0] returned_count;
        logic             last;
    } t_slot;

endpackage

[hdl/brb_front.sv]
// front end: accepts input words, classifies them and queues commands
// depends on brb_pkg
`timescale 1ns / 1ps

module brb_front
    import brb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_word,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    localparam int QAW = $clog2(CQ_DEPTH);
    localparam int QCW = $clog2(CQ_DEPTH + 1);

    t_cmd           r_q [CQ_DEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QCW-1:0] r_qc, n_qc;
    t_cmd           cmd_in;
    logic           push;
    logic           pop;

    always_comb begin
        cmd_in.contig     = 1'b0;
        cmd_in.count      = i_in_word.count;
        cmd_in.count_zero = (i_in_word.count == '0);
        cmd_in.data_byte  = i_in_word.data_byte;
        cmd_in.last_byte  = i_in_word.last_byte;
        unique case (i_in_word.operation)
            OP_WRITE: begin
                cmd_in.kind = CK_WRITE;
            end
            OP_PEEK: begin
                cmd_in.kind = CK_PEEK;
            end
            OP_ADVANCE: begin
                cmd_in.kind = CK_ADVANCE;
            end
            OP_PEEK_CONTIG: begin
                cmd_in.kind   = CK_PEEK;
                cmd_in.contig = 1'b1;
            end
            default: begin
                cmd_in.kind = CK_ADVANCE;
            end
        endcase
    end

    assign o_in_stall  = (r_qc == QCW'(CQ_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_qc != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp = push ? QAW'(r_wp + 1'b1) : r_wp;
        n_rp = pop ? QAW'(r_rp + 1'b1) : r_rp;
        n_qc = QCW'(r_qc + QCW'(push) - QCW'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_qc <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_qc <= n_qc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

[hdl/brb_back.sv]
// back end: ring store, head/tail/fill bookkeeping, peek sequencer, result queue
// depends on brb_pkg and byte_ring_buffer_assert.svh
`timescale 1ns / 1ps
`include "byte_ring_buffer_assert.svh"

module brb_back
    import brb_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_word
);

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int FW  = AW + 1;
    localparam int CW  = CNT_W;
    localparam int OAW = $clog2(OQ_DEPTH);
    localparam int OCW = $clog2(OQ_DEPTH + 1);

    // ring store, read data registered
    logic [7:0]     r_mem [BUFFER_DEPTH];
    logic [7:0]     r_rd_data;

    t_back_state    r_state, n_state;
    logic [AW-1:0]  r_head, n_head;
    logic [AW-1:0]  r_tail, n_tail;
    logic [FW-1:0]  r_fill, n_fill;
    logic           r_run_act, n_run_act;
    logic           r_run_rej, n_run_rej;
    logic [CW-1:0]  r_run_len, n_run_len;
    logic [CW-1:0]  r_run_wr, n_run_wr;
    logic [CW-1:0]  r_pk_n, n_pk_n;
    logic [CW-1:0]  r_pk_left, n_pk_left;
    logic [AW-1:0]  r_pk_idx, n_pk_idx;
    logic           r_s1_vld, n_s1_vld;
    t_slot          r_s1, n_s1;

    t_out_item      r_oq [OQ_DEPTH];
    logic [OAW-1:0] r_oq_wp, r_oq_rp;
    logic [OCW-1:0] r_oc;

    logic           issue_ok;
    logic           cmd_take;
    logic [CW-1:0]  fill_x, free_x, room_x;
    logic [CW-1:0]  pk_n0, pk_n;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic           w_start, w_rej, w_store;
    logic [CW-1:0]  w_len, w_wr, w_wr_new;
    logic           adv_ok;
    logic           out_pop;
    t_out_item      s1_item;

    // a slot is issued only when the result queue can take it plus the one in flight
    assign issue_ok    = (OCW'(r_oc + OCW'(r_s1_vld)) <= OCW'(OQ_DEPTH - 1));
    assign o_cmd_ready = (r_state == BK_IDLE) && issue_ok;
    assign cmd_take    = i_cmd_valid && o_cmd_ready;

    always_comb begin
        fill_x = CW'(r_fill);
        free_x = CW'(FW'(BUFFER_DEPTH) - r_fill);
        room_x = CW'(FW'(BUFFER_DEPTH) - FW'(r_tail));
        pk_n0  = (i_cmd.count < fill_x) ? i_cmd.count : fill_x;
        pk_n   = (i_cmd.contig && (pk_n0 > room_x)) ? room_x : pk_n0;

        // first word of a run decides for the whole run
        w_start  = !r_run_act;
        w_rej    = w_start ? (i_cmd.count_zero || (i_cmd.count > free_x)) : r_run_rej;
        w_len    = w_start ? i_cmd.count : r_run_len;
        w_wr     = w_start ? '0 : r_run_wr;
        w_store  = !w_rej && (w_wr < w_len);
        w_wr_new = CW'(w_wr + CW'(w_store));

        adv_ok = !i_cmd.count_zero && (i_cmd.count <= fill_x);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (cmd_take && (i_cmd.kind == CK_PEEK) && (pk_n > CW'(1))) begin
                    n_state = BK_PEEK;
                end
            end
            BK_PEEK: begin
                if (issue_ok && (r_pk_left == CW'(1))) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_run_act = r_run_act;
        n_run_rej = r_run_rej;
        n_run_len = r_run_len;
        n_run_wr  = r_run_wr;
        n_pk_n    = r_pk_n;
        n_pk_left = r_pk_left;
        n_pk_idx  = r_pk_idx;
        n_s1_vld  = 1'b0;
        n_s1      = r_s1;
        rd_en     = 1'b0;
        rd_addr   = r_tail;
        wr_en     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (cmd_take) begin
                    n_s1_vld = 1'b1;
                    n_s1.is_data = 1'b0;
                    n_s1.last    = 1'b1;
                    unique case (i_cmd.kind)
                        CK_WRITE: begin
                            wr_en  = w_store;
                            n_head = w_store ? AW'(r_head + 1'b1) : r_head;
                            n_s1.status         = w_store ? ST_WR_OK : ST_WR_REJ;
                            n_s1.returned_count = w_rej ? '0 : w_wr_new;
                            n_s1.last           = i_cmd.last_byte;
                            if (i_cmd.last_byte) begin
                                if (!w_rej) begin
                                    n_fill = FW'(r_fill + FW'(w_wr_new));
                                end
                                n_run_act = 1'b0;
                                n_run_rej = 1'b0;
                                n_run_len = '0;
                                n_run_wr  = '0;
                            end else begin
                                n_run_act = 1'b1;
                                n_run_rej = w_rej;
                                n_run_len = w_len;
                                n_run_wr  = w_wr_new;
                            end
                        end
                        CK_ADVANCE: begin
                            if (adv_ok) begin
                                n_tail = AW'(r_tail + AW'(i_cmd.count));
                                n_fill = FW'(r_fill - FW'(i_cmd.count));
                                n_s1.status         = ST_ADV;
                                n_s1.returned_count = i_cmd.count;
                            end else begin
                                n_s1.status         = ST_ADV_IGN;
                                n_s1.returned_count = '0;
                            end
                        end
                        CK_PEEK: begin
                            if (pk_n == '0) begin
                                n_s1.status         = ST_NONE;
                                n_s1.returned_count = '0;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_tail;
                                n_s1.is_data        = 1'b1;
                                n_s1.status         = ST_DATA;
                                n_s1.returned_count = pk_n;
                                n_s1.last           = (pk_n == CW'(1));
                                n_pk_n    = pk_n;
                                n_pk_left = CW'(pk_n - 1'b1);
                                n_pk_idx  = AW'(r_tail + 1'b1);
                            end
                        end
                        default: begin
                            n_s1_vld = 1'b0;
                        end
                    endcase
                end
            end
            BK_PEEK: begin
                if (issue_ok) begin
                    rd_en    = 1'b1;
                    rd_addr  = r_pk_idx;
                    n_s1_vld = 1'b1;
                    n_s1.is_data        = 1'b1;
                    n_s1.status         = ST_DATA;
                    n_s1.returned_count = r_pk_n;
                    n_s1.last           = (r_pk_left == CW'(1));
                    n_pk_left = CW'(r_pk_left - 1'b1);
                    n_pk_idx  = AW'(r_pk_idx + 1'b1);
                end
            end
            default: begin
                n_s1_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_head] <= i_cmd.data_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
            r_run_act <= 1'b0;
            r_run_rej <= 1'b0;
            r_run_len <= '0;
            r_run_wr  <= '0;
            r_pk_n    <= '0;
            r_pk_left <= '0;
            r_pk_idx  <= '0;
            r_s1_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_fill    <= n_fill;
            r_run_act <= n_run_act;
            r_run_rej <= n_run_rej;
            r_run_len <= n_run_len;
            r_run_wr  <= n_run_wr;
            r_pk_n    <= n_pk_n;
            r_pk_left <= n_pk_left;
            r_pk_idx  <= n_pk_idx;
            r_s1_vld  <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // result queue decouples the back end from a stalling receiver
    always_comb begin
        s1_item.data_byte_out  = r_s1.is_data ? r_rd_data : 8'd0;
        s1_item.status         = r_s1.status;
        s1_item.returned_count = r_s1.returned_count;
        s1_item.last           = r_s1.last;
    end

    assign o_out_valid = (r_oc != '0);
    assign o_out_word  = r_oq[r_oq_rp];
    assign out_pop     = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp <= '0;
            r_oq_rp <= '0;
            r_oc    <= '0;
        end else begin
            if (r_s1_vld) begin
                r_oq_wp <= OAW'(r_oq_wp + 1'b1);
            end
            if (out_pop) begin
                r_oq_rp <= OAW'(r_oq_rp + 1'b1);
            end
            r_oc <= OCW'(r_oc + OCW'(r_s1_vld) - OCW'(out_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_oq[r_oq_wp] <= s1_item;
        end
    end

    `BRB_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= FW'(BUFFER_DEPTH))
    `BRB_ASSERT_SAME(a_ring_consistent, !r_run_act, AW'(r_head - r_tail) == r_fill[AW-1:0])
    `BRB_ASSERT_SAME(a_oq_no_overflow, r_s1_vld, r_oc < OCW'(OQ_DEPTH))
    `BRB_ASSERT_SAME(a_peek_left, r_state == BK_PEEK, r_pk_left != '0)
    `BRB_ASSERT_NEXT(a_store_read_lands, rd_en, r_s1_vld && r_s1.is_data)

endmodule

[hdl/byte_ring_buffer.sv]
// top level of the byte ring buffer: front end and back end joined by the command queue
// depends on brb_pkg, brb_front and brb_back
`timescale 1ns / 1ps

// Byte FIFO kept in a ring of BUFFER_DEPTH entries (a power of two).
// Input channel: i_in_valid / o_in_stall with one t_in_item word per handshake.
// Operation write stores one byte of a run, peek and contiguous peek return
// bytes from the tail without consuming them, advance consumes count bytes if stored.
// Output channel: o_out_valid / i_out_stall with one t_out_item word per handshake;
// every input word gives at least one result word, a peek gives one per byte.
// The first result of a word passes the command queue, then the issue stage with
// its store read, then the result queue, once the back end is free to take it.
// Write and advance words go through at one per cycle while the receiver does not
// stall; a peek holds the back end until all its bytes are issued, as the single
// store read port delivers one byte per cycle, so the next word waits behind it.
// When the receiver stalls, the four-entry result queue fills, the back end stops
// issuing, the two-entry command queue fills and o_in_stall rises.
// Reset clears head, tail, fill count, run state and both queues; the store
// itself is left as it is and is only read where it was written.

module byte_ring_buffer
    import brb_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_word
);

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    brb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    brb_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
